FILE: src/chained_block_pool_manager_macros.svh
// ---------------------------------------------------------------------------
// chained_block_pool_manager_macros.svh
// Assertion macros shared by the block pool checker.
// ---------------------------------------------------------------------------
`ifndef CHAINED_BLOCK_POOL_MANAGER_MACROS_SVH
`define CHAINED_BLOCK_POOL_MANAGER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CBPM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CBPM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cbpm_pkg.sv
// ---------------------------------------------------------------------------
// cbpm_pkg
// Widths, codes and types of the chained block pool manager.
// ---------------------------------------------------------------------------
package cbpm_pkg;

    localparam int NUM_BLOCKS_DEF = 64;

    localparam int CMD_W     = 3;
    localparam int BLK_W     = 6;
    localparam int LINK_W    = 7;
    localparam int CNT_W     = 7;
    localparam int LEN_W     = 13;
    localparam int BYTES_W   = 19;
    localparam int ACC_W     = 20;
    localparam int FAIL_W    = 32;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_OUT   = 64;
    localparam int RES_AW    = 6;

    localparam logic [LINK_W-1:0] NIL_LINK = 7'h7F;
    localparam logic [LEN_W-1:0]  BB_RESET = 13'd64;
    localparam logic [LEN_W-1:0]  BB_MIN   = 13'd4;
    localparam logic [LEN_W-1:0]  BB_MAX   = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LINK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_WALK  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_A_CHK,
        ST_A_RD,
        ST_A_UPD,
        ST_A_L1,
        ST_A_L2,
        ST_T_RD,
        ST_T_EV,
        ST_F_WR,
        ST_M_RD,
        ST_M_EV,
        ST_L_W1,
        ST_L_W2,
        ST_P_WR,
        ST_Q_RD,
        ST_Q_EV,
        ST_W_RD,
        ST_W_EV,
        ST_D_LOOP,
        ST_O_RD,
        ST_O_WAIT
    } state_t;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic             ok;
        logic [LEN_W-1:0] used;
        logic             chain_end;
    } res_t;

endpackage

FILE: src/chained_block_pool_manager.sv
// ---------------------------------------------------------------------------
// chained_block_pool_manager
// Fixed block pool with a linked free list, chain commands and a chain FIFO.
//
// The pool holds block_count blocks linked through a next-link table. A
// request carries a command (alloc, free, mark used, link, push, pop, walk,
// drain); the block takes one request at a time and is not ready until
// every response of that request has been taken. Responses are collected
// in a 64-entry buffer and then streamed out, each one carrying the free
// count, low-water mark and failure count as they stand after the whole
// request. One sequencer drives a link/length/end-mark table with one read
// port, one write port and a registered read, so every step through a chain
// passes a read state and a state that uses the read data, and each response
// passes a read state and a wait state as it drains from the buffer. After
// reset and after each block_count write the link table is rebuilt by a
// sweep over all NUM_BLOCKS entries, during which no request is taken;
// configuration writes are still taken.
// ---------------------------------------------------------------------------
module chained_block_pool_manager #(
    parameter int NUM_BLOCKS = cbpm_pkg::NUM_BLOCKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [cbpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbpm_pkg::CFG_W-1:0]      cfg_wdata,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cbpm_pkg::CMD_W-1:0]      s_command,
    input  logic [cbpm_pkg::BLK_W-1:0]      s_block_index,
    input  logic [cbpm_pkg::BLK_W-1:0]      s_other_block,
    input  logic [cbpm_pkg::BYTES_W-1:0]    s_byte_count,
    // response channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cbpm_pkg::BLK_W-1:0]      m_out_block,
    output logic                            m_ok,
    output logic [cbpm_pkg::LEN_W-1:0]      m_used_bytes,
    output logic                            m_chain_end,
    output logic                            m_last,
    output logic [cbpm_pkg::CNT_W-1:0]      m_free_blocks,
    output logic [cbpm_pkg::CNT_W-1:0]      m_min_free_blocks,
    output logic [cbpm_pkg::FAIL_W-1:0]     m_failed_allocs
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LW = cbpm_pkg::LINK_W;
    localparam int CW = cbpm_pkg::CNT_W;
    localparam logic [LW-1:0] NUM_LINK = LW'(NUM_BLOCKS);

    // a link at or above the block count of the table marks a chain end
    function automatic logic link_null(input logic [LW-1:0] v);
        return v >= NUM_LINK;
    endfunction

    // ---------------- state ----------------
    cbpm_pkg::state_t state_reg, state_next;

    // configuration and pool bookkeeping (reset)
    logic [cbpm_pkg::LEN_W-1:0]  bb_reg, bb_next;        // block_bytes
    logic [CW-1:0]               cnt_reg, cnt_next;      // block_count
    logic [LW-1:0]               fh_reg, fh_next;        // free list head
    logic [CW-1:0]               ft_reg, ft_next;        // free count
    logic [CW-1:0]               low_reg, low_next;      // low-water mark
    logic [cbpm_pkg::FAIL_W-1:0] fail_reg, fail_next;
    logic [LW-1:0]               qh_reg, qh_next;        // FIFO head
    logic [LW-1:0]               qt_reg, qt_next;        // FIFO tail
    logic [LW-1:0]               sweep_reg, sweep_next;

    // request and working registers (no reset)
    logic [cbpm_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [cbpm_pkg::BLK_W-1:0]   bi_reg, bi_next;
    logic [cbpm_pkg::BLK_W-1:0]   ob_reg, ob_next;
    logic [cbpm_pkg::BYTES_W-1:0] bytes_reg, bytes_next;
    logic [LW-1:0]                cur_reg, cur_next;     // chain cursor
    logic [LW-1:0]                head_reg, head_next;   // chain head
    logic [LW-1:0]                nb_reg, nb_next;       // newly taken block
    logic [CW-1:0]                steps_reg, steps_next;
    logic [CW-1:0]                taken_reg, taken_next;
    logic [cbpm_pkg::ACC_W-1:0]   acc_reg, acc_next;     // taken * block_bytes
    logic [CW-1:0]                k_reg, k_next;         // responses stored
    logic [cbpm_pkg::RES_AW-1:0]  j_reg, j_next;         // responses sent
    logic [CW-1:0]                vis_reg, vis_next;
    logic [CW-1:0]                lim_reg, lim_next;

    // ---------------- link table ----------------
    logic [LW-1:0]              link_mem [NUM_BLOCKS];
    logic [cbpm_pkg::LEN_W-1:0] used_mem [NUM_BLOCKS];
    logic                       end_mem  [NUM_BLOCKS];

    logic [AW-1:0]              mem_raddr, mem_waddr;
    logic                       lk_we, us_we, en_we;
    logic [LW-1:0]              lk_wdata;
    logic [cbpm_pkg::LEN_W-1:0] us_wdata;
    logic                       en_wdata;
    logic [LW-1:0]              lk_rd;
    logic [cbpm_pkg::LEN_W-1:0] us_rd;
    logic                       en_rd;

    always_ff @(posedge aclk) begin
        if (lk_we) begin
            link_mem[mem_waddr] <= lk_wdata;
        end
        if (us_we) begin
            used_mem[mem_waddr] <= us_wdata;
        end
        if (en_we) begin
            end_mem[mem_waddr] <= en_wdata;
        end
        lk_rd <= link_mem[mem_raddr];
        us_rd <= used_mem[mem_raddr];
        en_rd <= end_mem[mem_raddr];
    end

    // ---------------- response buffer ----------------
    cbpm_pkg::res_t res_mem [cbpm_pkg::MAX_OUT];
    cbpm_pkg::res_t res_wdata, res_rd;
    logic           res_we;

    always_ff @(posedge aclk) begin
        if (res_we) begin
            res_mem[k_reg[cbpm_pkg::RES_AW-1:0]] <= res_wdata;
        end
        res_rd <= res_mem[j_reg];
    end

    // ---------------- helpers ----------------
    logic          bad_bi, bad_ob;
    logic [CW-1:0] ft_dec;
    logic [CW:0]   ft_sum;
    logic [CW-1:0] ft_add;
    logic [cbpm_pkg::FAIL_W-1:0] fail_inc;
    logic [CW-1:0] room, lim_new;
    logic          walk_end;
    logic [cbpm_pkg::LEN_W-1:0] cfg_bb;
    logic [CW-1:0] cfg_cnt;

    always_comb begin
        bad_bi   = {1'b0, bi_reg} >= cnt_reg;
        bad_ob   = {1'b0, ob_reg} >= cnt_reg;
        ft_dec   = (ft_reg == '0) ? '0 : ft_reg - CW'(1);
        ft_sum   = {1'b0, ft_reg} + {1'b0, steps_reg};
        ft_add   = ft_sum[CW] ? '1 : ft_sum[CW-1:0];
        fail_inc = (fail_reg == '1) ? fail_reg : fail_reg + 1'b1;
        room     = CW'(cbpm_pkg::MAX_OUT) - k_reg;
        lim_new  = (room < cnt_reg) ? room : cnt_reg;
        walk_end = en_rd || link_null(lk_rd);
        // register writes saturate into their legal ranges (block_count from the low CNT_W bits)
        if (cfg_wdata < cbpm_pkg::BB_MIN) begin
            cfg_bb = cbpm_pkg::BB_MIN;
        end else if (cfg_wdata > cbpm_pkg::BB_MAX) begin
            cfg_bb = cbpm_pkg::BB_MAX;
        end else begin
            cfg_bb = cfg_wdata;
        end
        if (cfg_wdata[CW-1:0] == '0) begin
            cfg_cnt = CW'(1);
        end else if (cfg_wdata[CW-1:0] > CW'(NUM_BLOCKS)) begin
            cfg_cnt = CW'(NUM_BLOCKS);
        end else begin
            cfg_cnt = cfg_wdata[CW-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        bb_next    = bb_reg;
        cnt_next   = cnt_reg;
        fh_next    = fh_reg;
        ft_next    = ft_reg;
        low_next   = low_reg;
        fail_next  = fail_reg;
        qh_next    = qh_reg;
        qt_next    = qt_reg;
        sweep_next = sweep_reg;
        cmd_next   = cmd_reg;
        bi_next    = bi_reg;
        ob_next    = ob_reg;
        bytes_next = bytes_reg;
        cur_next   = cur_reg;
        head_next  = head_reg;
        nb_next    = nb_reg;
        steps_next = steps_reg;
        taken_next = taken_reg;
        acc_next   = acc_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        vis_next   = vis_reg;
        lim_next   = lim_reg;

        mem_raddr  = cur_reg[AW-1:0];
        mem_waddr  = cur_reg[AW-1:0];
        lk_we      = 1'b0;
        us_we      = 1'b0;
        en_we      = 1'b0;
        lk_wdata   = cbpm_pkg::NIL_LINK;
        us_wdata   = bb_reg;
        en_wdata   = 1'b0;
        res_we     = 1'b0;
        res_wdata  = '0;

        case (state_reg)
            cbpm_pkg::ST_INIT: begin
                // rebuild the free chain 0..count-1, one entry a cycle
                lk_we     = 1'b1;
                mem_waddr = sweep_reg[AW-1:0];
                lk_wdata  = ((sweep_reg + LW'(1)) < cnt_reg) ? sweep_reg + LW'(1)
                                                             : cbpm_pkg::NIL_LINK;
                if (sweep_reg == LW'(NUM_BLOCKS - 1)) begin
                    state_next = cbpm_pkg::ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + LW'(1);
                end
            end

            cbpm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_command;
                    bi_next    = s_block_index;
                    ob_next    = s_other_block;
                    bytes_next = s_byte_count;
                    k_next     = '0;
                    j_next     = '0;
                    taken_next = '0;
                    state_next = cbpm_pkg::ST_DECODE;
                end
            end

            cbpm_pkg::ST_DECODE: begin
                state_next = cbpm_pkg::ST_O_RD;
                case (cmd_reg)
                    cbpm_pkg::CMD_ALLOC: begin
                        state_next = cbpm_pkg::ST_A_RD;
                    end
                    cbpm_pkg::CMD_FREE: begin
                        if (bad_bi) begin
                            res_we = 1'b1;
                            k_next = k_reg + CW'(1);
                        end else begin
                            head_next  = {1'b0, bi_reg};
                            cur_next   = {1'b0, bi_reg};
                            steps_next = CW'(1);
                            state_next = cbpm_pkg::ST_T_RD;
                        end
                    end
                    cbpm_pkg::CMD_MARK: begin
                        if (bad_bi) begin
                            res_we = 1'b1;
                            k_next = k_reg + CW'(1);
                        end else begin
                            state_next = cbpm_pkg::ST_M_RD;
                        end
                    end
                    cbpm_pkg::CMD_LINK: begin
                        if (bad_bi || bad_ob) begin
                            res_we = 1'b1;
                            k_next = k_reg + CW'(1);
                        end else begin
                            cur_next   = {1'b0, bi_reg};
                            steps_next = CW'(1);
                            state_next = cbpm_pkg::ST_T_RD;
                        end
                    end
                    cbpm_pkg::CMD_PUSH: begin
                        if (bad_bi) begin
                            res_we = 1'b1;
                            k_next = k_reg + CW'(1);
                        end else begin
                            state_next = cbpm_pkg::ST_P_WR;
                        end
                    end
                    cbpm_pkg::CMD_POP: begin
                        if (link_null(qh_reg)) begin
                            res_we = 1'b1;
                            k_next = k_reg + CW'(1);
                        end else begin
                            head_next  = qh_reg;
                            cur_next   = qh_reg;
                            steps_next = CW'(1);
                            state_next = cbpm_pkg::ST_Q_RD;
                        end
                    end
                    cbpm_pkg::CMD_WALK: begin
                        if (bad_bi) begin
                            res_we = 1'b1;
                            k_next = k_reg + CW'(1);
                        end else begin
                            cur_next   = {1'b0, bi_reg};
                            vis_next   = '0;
                            lim_next   = lim_new;
                            state_next = cbpm_pkg::ST_W_RD;
                        end
                    end
                    default: begin
                        if (link_null(qh_reg)) begin
                            res_we = 1'b1;
                            k_next = k_reg + CW'(1);
                        end else begin
                            state_next = cbpm_pkg::ST_D_LOOP;
                        end
                    end
                endcase
            end

            // ---- allocation: take blocks off the free head ----
            cbpm_pkg::ST_A_RD: begin
                mem_raddr = fh_reg[AW-1:0];
                if (link_null(fh_reg)) begin
                    fail_next = fail_inc;
                    if (taken_reg == '0) begin
                        res_we     = 1'b1;
                        k_next     = k_reg + CW'(1);
                        state_next = cbpm_pkg::ST_O_RD;
                    end else begin
                        cur_next   = head_reg;
                        steps_next = CW'(1);
                        state_next = cbpm_pkg::ST_T_RD;
                    end
                end else begin
                    state_next = cbpm_pkg::ST_A_UPD;
                end
            end

            cbpm_pkg::ST_A_UPD: begin
                mem_waddr  = fh_reg[AW-1:0];
                lk_we      = 1'b1;
                lk_wdata   = cbpm_pkg::NIL_LINK;
                us_we      = 1'b1;
                us_wdata   = bb_reg;
                en_we      = 1'b1;
                en_wdata   = 1'b1;
                fh_next    = lk_rd;
                ft_next    = ft_dec;
                if (ft_dec < low_reg) begin
                    low_next = ft_dec;
                end
                taken_next = taken_reg + CW'(1);
                if (taken_reg == '0) begin
                    head_next  = fh_reg;
                    cur_next   = fh_reg;
                    acc_next   = cbpm_pkg::ACC_W'(bb_reg);
                    state_next = cbpm_pkg::ST_A_CHK;
                end else begin
                    nb_next    = fh_reg;
                    state_next = cbpm_pkg::ST_A_L1;
                end
            end

            cbpm_pkg::ST_A_L1: begin
                // old tail loses its end mark and points at the new block
                en_we      = 1'b1;
                en_wdata   = 1'b0;
                lk_we      = 1'b1;
                lk_wdata   = nb_reg;
                state_next = cbpm_pkg::ST_A_L2;
            end

            cbpm_pkg::ST_A_L2: begin
                mem_waddr  = nb_reg[AW-1:0];
                en_we      = 1'b1;
                en_wdata   = 1'b1;
                cur_next   = nb_reg;
                acc_next   = acc_reg + cbpm_pkg::ACC_W'(bb_reg);
                state_next = cbpm_pkg::ST_A_CHK;
            end

            cbpm_pkg::ST_A_CHK: begin
                if (acc_reg < cbpm_pkg::ACC_W'(bytes_reg)) begin
                    if (taken_reg >= cnt_reg) begin
                        fail_next  = fail_inc;
                        cur_next   = head_reg;
                        steps_next = CW'(1);
                        state_next = cbpm_pkg::ST_T_RD;
                    end else begin
                        state_next = cbpm_pkg::ST_A_RD;
                    end
                end else begin
                    res_we        = 1'b1;
                    res_wdata.blk = head_reg[cbpm_pkg::BLK_W-1:0];
                    res_wdata.ok  = 1'b1;
                    k_next        = k_reg + CW'(1);
                    state_next    = cbpm_pkg::ST_O_RD;
                end
            end

            // ---- tail search, bounded by block_count ----
            cbpm_pkg::ST_T_RD: begin
                state_next = cbpm_pkg::ST_T_EV;
            end

            cbpm_pkg::ST_T_EV: begin
                if (!link_null(lk_rd) && (steps_reg < cnt_reg)) begin
                    cur_next   = lk_rd;
                    steps_next = steps_reg + CW'(1);
                    state_next = cbpm_pkg::ST_T_RD;
                end else begin
                    case (cmd_reg)
                        cbpm_pkg::CMD_LINK: begin
                            state_next = cbpm_pkg::ST_L_W1;
                        end
                        cbpm_pkg::CMD_PUSH: begin
                            qt_next      = cur_reg;
                            res_we       = 1'b1;
                            res_wdata.ok = 1'b1;
                            k_next       = k_reg + CW'(1);
                            state_next   = cbpm_pkg::ST_O_RD;
                        end
                        default: begin
                            state_next = cbpm_pkg::ST_F_WR;
                        end
                    endcase
                end
            end

            // ---- return a chain to the free head ----
            cbpm_pkg::ST_F_WR: begin
                lk_we    = 1'b1;
                lk_wdata = fh_reg;
                fh_next  = head_reg;
                ft_next  = ft_add;
                case (cmd_reg)
                    cbpm_pkg::CMD_ALLOC: begin
                        res_we     = 1'b1;
                        k_next     = k_reg + CW'(1);
                        state_next = cbpm_pkg::ST_O_RD;
                    end
                    cbpm_pkg::CMD_FREE: begin
                        res_we       = 1'b1;
                        res_wdata.ok = 1'b1;
                        k_next       = k_reg + CW'(1);
                        state_next   = cbpm_pkg::ST_O_RD;
                    end
                    default: begin
                        state_next = cbpm_pkg::ST_D_LOOP;
                    end
                endcase
            end

            // ---- mark used bytes ----
            cbpm_pkg::ST_M_RD: begin
                mem_raddr  = bi_reg[AW-1:0];
                state_next = cbpm_pkg::ST_M_EV;
            end

            cbpm_pkg::ST_M_EV: begin
                mem_waddr = bi_reg[AW-1:0];
                if (bytes_reg < cbpm_pkg::BYTES_W'(us_rd)) begin
                    us_we    = 1'b1;
                    us_wdata = bytes_reg[cbpm_pkg::LEN_W-1:0];
                end
                res_we       = 1'b1;
                res_wdata.ok = 1'b1;
                k_next       = k_reg + CW'(1);
                state_next   = cbpm_pkg::ST_O_RD;
            end

            // ---- link: tail of first chain to other_block ----
            cbpm_pkg::ST_L_W1: begin
                en_we      = 1'b1;
                en_wdata   = 1'b0;
                lk_we      = 1'b1;
                lk_wdata   = {1'b0, ob_reg};
                state_next = cbpm_pkg::ST_L_W2;
            end

            cbpm_pkg::ST_L_W2: begin
                mem_waddr    = ob_reg[AW-1:0];
                en_we        = 1'b1;
                en_wdata     = 1'b1;
                res_we       = 1'b1;
                res_wdata.ok = 1'b1;
                k_next       = k_reg + CW'(1);
                state_next   = cbpm_pkg::ST_O_RD;
            end

            // ---- push: append chain to the FIFO ----
            cbpm_pkg::ST_P_WR: begin
                if (link_null(qh_reg) || link_null(qt_reg)) begin
                    qh_next = {1'b0, bi_reg};
                end else begin
                    mem_waddr = qt_reg[AW-1:0];
                    lk_we     = 1'b1;
                    lk_wdata  = {1'b0, bi_reg};
                end
                cur_next   = {1'b0, bi_reg};
                steps_next = CW'(1);
                state_next = cbpm_pkg::ST_T_RD;
            end

            // ---- pop: cut the first chain off the FIFO ----
            cbpm_pkg::ST_Q_RD: begin
                state_next = cbpm_pkg::ST_Q_EV;
            end

            cbpm_pkg::ST_Q_EV: begin
                if (!en_rd && !link_null(lk_rd) && (steps_reg < cnt_reg)) begin
                    cur_next   = lk_rd;
                    steps_next = steps_reg + CW'(1);
                    state_next = cbpm_pkg::ST_Q_RD;
                end else begin
                    if (link_null(lk_rd)) begin
                        qh_next = cbpm_pkg::NIL_LINK;
                        qt_next = cbpm_pkg::NIL_LINK;
                    end else begin
                        qh_next = lk_rd;
                    end
                    lk_we    = 1'b1;
                    lk_wdata = cbpm_pkg::NIL_LINK;
                    if (cmd_reg == cbpm_pkg::CMD_POP) begin
                        res_we        = 1'b1;
                        res_wdata.blk = head_reg[cbpm_pkg::BLK_W-1:0];
                        res_wdata.ok  = 1'b1;
                        k_next        = k_reg + CW'(1);
                        state_next    = cbpm_pkg::ST_O_RD;
                    end else begin
                        cur_next   = head_reg;
                        vis_next   = '0;
                        lim_next   = lim_new;
                        state_next = cbpm_pkg::ST_W_RD;
                    end
                end
            end

            // ---- walk: one response per block ----
            cbpm_pkg::ST_W_RD: begin
                if (vis_reg < lim_reg) begin
                    state_next = cbpm_pkg::ST_W_EV;
                end else if (cmd_reg == cbpm_pkg::CMD_WALK) begin
                    state_next = cbpm_pkg::ST_O_RD;
                end else begin
                    cur_next   = head_reg;
                    steps_next = CW'(1);
                    state_next = cbpm_pkg::ST_T_RD;
                end
            end

            cbpm_pkg::ST_W_EV: begin
                res_we              = 1'b1;
                res_wdata.blk       = cur_reg[cbpm_pkg::BLK_W-1:0];
                res_wdata.ok        = 1'b1;
                res_wdata.used      = us_rd;
                res_wdata.chain_end = walk_end;
                k_next              = k_reg + CW'(1);
                vis_next            = vis_reg + CW'(1);
                if (!walk_end) begin
                    cur_next   = lk_rd;
                    state_next = cbpm_pkg::ST_W_RD;
                end else if (cmd_reg == cbpm_pkg::CMD_WALK) begin
                    state_next = cbpm_pkg::ST_O_RD;
                end else begin
                    cur_next   = head_reg;
                    steps_next = CW'(1);
                    state_next = cbpm_pkg::ST_T_RD;
                end
            end

            // ---- drain: pop, walk and free until empty or buffer full ----
            cbpm_pkg::ST_D_LOOP: begin
                if (!link_null(qh_reg) && (k_reg < CW'(cbpm_pkg::MAX_OUT))) begin
                    head_next  = qh_reg;
                    cur_next   = qh_reg;
                    steps_next = CW'(1);
                    state_next = cbpm_pkg::ST_Q_RD;
                end else begin
                    state_next = cbpm_pkg::ST_O_RD;
                end
            end

            // ---- response streaming ----
            cbpm_pkg::ST_O_RD: begin
                state_next = cbpm_pkg::ST_O_WAIT;
            end

            cbpm_pkg::ST_O_WAIT: begin
                if (m_ready) begin
                    if ((CW'(j_reg) + CW'(1)) == k_reg) begin
                        state_next = cbpm_pkg::ST_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = cbpm_pkg::ST_O_RD;
                    end
                end
            end

            default: begin
                state_next = cbpm_pkg::ST_IDLE;
            end
        endcase

        // register writes; a block_count write rebuilds the pool
        if (cfg_wr_en) begin
            case (cfg_index)
                cbpm_pkg::REG_BLOCK_BYTES: begin
                    bb_next = cfg_bb;
                end
                cbpm_pkg::REG_BLOCK_COUNT: begin
                    cnt_next   = cfg_cnt;
                    fh_next    = '0;
                    ft_next    = cfg_cnt;
                    low_next   = cfg_cnt;
                    fail_next  = '0;
                    qh_next    = cbpm_pkg::NIL_LINK;
                    qt_next    = cbpm_pkg::NIL_LINK;
                    sweep_next = '0;
                    state_next = cbpm_pkg::ST_INIT;
                end
                default: begin
                    bb_next = bb_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbpm_pkg::ST_INIT;
            bb_reg    <= cbpm_pkg::BB_RESET;
            cnt_reg   <= CW'(NUM_BLOCKS);
            fh_reg    <= '0;
            ft_reg    <= CW'(NUM_BLOCKS);
            low_reg   <= CW'(NUM_BLOCKS);
            fail_reg  <= '0;
            qh_reg    <= cbpm_pkg::NIL_LINK;
            qt_reg    <= cbpm_pkg::NIL_LINK;
            sweep_reg <= '0;
        end else begin
            state_reg <= state_next;
            bb_reg    <= bb_next;
            cnt_reg   <= cnt_next;
            fh_reg    <= fh_next;
            ft_reg    <= ft_next;
            low_reg   <= low_next;
            fail_reg  <= fail_next;
            qh_reg    <= qh_next;
            qt_reg    <= qt_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        bi_reg    <= bi_next;
        ob_reg    <= ob_next;
        bytes_reg <= bytes_next;
        cur_reg   <= cur_next;
        head_reg  <= head_next;
        nb_reg    <= nb_next;
        steps_reg <= steps_next;
        taken_reg <= taken_next;
        acc_reg   <= acc_next;
        k_reg     <= k_next;
        j_reg     <= j_next;
        vis_reg   <= vis_next;
        lim_reg   <= lim_next;
    end

    // ---------------- ports ----------------
    assign s_ready           = (state_reg == cbpm_pkg::ST_IDLE);
    assign m_valid           = (state_reg == cbpm_pkg::ST_O_WAIT);
    assign m_out_block       = res_rd.blk;
    assign m_ok              = res_rd.ok;
    assign m_used_bytes      = res_rd.used;
    assign m_chain_end       = res_rd.chain_end;
    assign m_last            = ((CW'(j_reg) + CW'(1)) == k_reg);
    assign m_free_blocks     = ft_reg;
    assign m_min_free_blocks = low_reg;
    assign m_failed_allocs   = fail_reg;

endmodule

FILE: src/cbpm_checker.sv
// ---------------------------------------------------------------------------
// cbpm_checker
// Port-level checks of the chained block pool manager, bound to the top.
// ---------------------------------------------------------------------------
`include "chained_block_pool_manager_macros.svh"

module cbpm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [cbpm_pkg::BLK_W-1:0]  m_out_block,
    input logic                        m_ok,
    input logic [cbpm_pkg::CNT_W-1:0]  m_free_blocks,
    input logic [cbpm_pkg::CNT_W-1:0]  m_min_free_blocks
);

    // stalled response holds
    `CBPM_ASSERT_NEXT(a_resp_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_block), "stalled response changed")

    // one request at a time
    `CBPM_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_valid && s_ready, !s_ready, "ready right after a request")

    // no new request while responses are pending
    `CBPM_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "ready while responding")

    // low-water mark never above the free count
    `CBPM_ASSERT_NOW(a_low_water, aclk, aresetn, m_valid, m_min_free_blocks <= m_free_blocks, "low-water above free count")

    // failed responses carry no block
    `CBPM_ASSERT_NOW(a_fail_block, aclk, aresetn, m_valid && !m_ok, m_out_block == '0, "failed response names a block")

endmodule

bind chained_block_pool_manager cbpm_checker u_cbpm_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_out_block       (m_out_block),
    .m_ok              (m_ok),
    .m_free_blocks     (m_free_blocks),
    .m_min_free_blocks (m_min_free_blocks)
);

FILE: bench/tb_chained_block_pool_manager.sv
// ---------------------------------------------------------------------------
// tb_chained_block_pool_manager
// Self-checking bench for the chained block pool manager. A scoreboard keeps
// its own copy of the link table, free list and chain FIFO, predicts every
// response of each accepted request and checks the response stream in order.
// Directed requests come first, then random chain traffic over several
// block size / block count settings, with random gaps on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
    logic [cbpm_pkg::BLK_W-1:0]  blk;
    logic                        ok;
    logic [cbpm_pkg::LEN_W-1:0]  used;
    logic                        chain_end;
    logic                        last;
    logic [cbpm_pkg::CNT_W-1:0]  free_cnt;
    logic [cbpm_pkg::CNT_W-1:0]  low_water;
    logic [cbpm_pkg::FAIL_W-1:0] fail_cnt;
} pool_resp_t;

class pool_scoreboard;
    int unsigned link_tbl[64];
    int unsigned len_tbl[64];
    int unsigned end_tbl[64];
    int unsigned free_head, free_cnt, low_water, fifo_head, fifo_tail;
    int unsigned blk_bytes, blk_count;
    logic [cbpm_pkg::FAIL_W-1:0] fail_cnt;
    pool_resp_t expected_resps[$];
    pool_resp_t burst[$];
    int unsigned mismatches, resp_count, req_count;

    function new();
        foreach (len_tbl[i]) begin
            len_tbl[i] = 0;
            end_tbl[i] = 0;
        end
        blk_bytes = 64;
        blk_count = 64;
        rebuild();
    endfunction

    function bit is_nil(int unsigned v);
        return v >= 64;
    endfunction

    function void rebuild();
        for (int i = 0; i < 64; i++)
            link_tbl[i] = (i + 1 < blk_count) ? i + 1 : cbpm_pkg::NIL_LINK;
        free_head = 0;
        free_cnt  = blk_count;
        low_water = blk_count;
        fail_cnt  = '0;
        fifo_head = cbpm_pkg::NIL_LINK;
        fifo_tail = cbpm_pkg::NIL_LINK;
    endfunction

    function int unsigned tail_of(int unsigned x, output int unsigned cnt);
        int unsigned steps;
        steps = 1;
        while (!is_nil(link_tbl[x]) && steps < blk_count) begin
            x = link_tbl[x];
            steps++;
        end
        cnt = steps;
        return x;
    endfunction

    function void free_chain(int unsigned x);
        int unsigned c, t;
        t = tail_of(x, c);
        link_tbl[t] = free_head;
        free_head = x;
        free_cnt = (free_cnt + c > 127) ? 127 : free_cnt + c;
    endfunction

    function void count_fail();
        if (fail_cnt != '1) fail_cnt++;
    endfunction

    function int unsigned take_block();
        int unsigned b;
        b = free_head;
        if (is_nil(b)) return cbpm_pkg::NIL_LINK;
        free_head = link_tbl[b];
        if (free_cnt > 0) free_cnt--;
        link_tbl[b] = cbpm_pkg::NIL_LINK;
        len_tbl[b] = blk_bytes;
        end_tbl[b] = 1;
        if (free_cnt < low_water) low_water = free_cnt;
        return b;
    endfunction

    function bit alloc_chain(int unsigned bytes, output int unsigned head);
        int unsigned need, taken, h, t, p;
        need = (bytes == 0) ? 1 : (bytes + blk_bytes - 1) / blk_bytes;
        taken = 1;
        head = 0;
        h = take_block();
        if (is_nil(h)) begin
            count_fail();
            return 0;
        end
        t = h;
        while (taken < need) begin
            p = (taken >= blk_count) ? cbpm_pkg::NIL_LINK : take_block();
            if (is_nil(p)) begin
                count_fail();
                free_chain(h);
                return 0;
            end
            end_tbl[t] = 0;
            end_tbl[p] = 1;
            link_tbl[t] = p;
            t = p;
            taken++;
        end
        head = h;
        return 1;
    endfunction

    // pops one chain: up to the first end mark, a null link or block_count steps
    function int unsigned pop_chain();
        int unsigned h, t, steps;
        h = fifo_head;
        t = h;
        steps = 1;
        if (is_nil(h)) return cbpm_pkg::NIL_LINK;
        while (end_tbl[t] != 1 && !is_nil(link_tbl[t]) && steps < blk_count) begin
            t = link_tbl[t];
            steps++;
        end
        fifo_head = link_tbl[t];
        if (is_nil(fifo_head)) begin
            fifo_head = cbpm_pkg::NIL_LINK;
            fifo_tail = cbpm_pkg::NIL_LINK;
        end
        link_tbl[t] = cbpm_pkg::NIL_LINK;
        return h;
    endfunction

    function void put(int unsigned blk, bit ok, int unsigned used, bit ce);
        pool_resp_t r;
        r = '0;
        r.blk = blk[cbpm_pkg::BLK_W-1:0];
        r.ok = ok;
        r.used = used[cbpm_pkg::LEN_W-1:0];
        r.chain_end = ce;
        burst.push_back(r);
    endfunction

    function void walk_emit(int unsigned x, int unsigned budget);
        int unsigned lim, visited;
        bit at_end;
        lim = (budget < blk_count) ? budget : blk_count;
        visited = 0;
        while (visited < lim) begin
            at_end = (end_tbl[x] == 1) || is_nil(link_tbl[x]);
            put(x, 1, len_tbl[x], at_end);
            visited++;
            if (at_end) break;
            x = link_tbl[x];
        end
    endfunction

    function void set_reg(logic [cbpm_pkg::CFG_IDX_W-1:0] idx,
                          logic [cbpm_pkg::CFG_W-1:0] val);
        int unsigned v;
        v = val;
        if (idx == cbpm_pkg::REG_BLOCK_BYTES) begin
            blk_bytes = (v < 4) ? 4 : ((v > 4096) ? 4096 : v);
        end else begin
            v = v & 'h7F;
            blk_count = (v < 1) ? 1 : ((v > 64) ? 64 : v);
            rebuild();
        end
    endfunction

    // predicts all responses of one accepted request; hands back the first one's block and ok
    function void note_request(logic [cbpm_pkg::CMD_W-1:0] cmd, int unsigned bi,
                               int unsigned ob, int unsigned bytes,
                               output int unsigned blk0, output bit ok0);
        bit bad;
        int unsigned h, c, t;
        bad = bi >= blk_count;
        burst.delete();
        req_count++;
        case (cmd)
            cbpm_pkg::CMD_ALLOC: begin
                if (alloc_chain(bytes, h)) put(h, 1, 0, 0);
                else put(0, 0, 0, 0);
            end
            cbpm_pkg::CMD_FREE: begin
                if (!bad) free_chain(bi);
                put(0, !bad, 0, 0);
            end
            cbpm_pkg::CMD_MARK: begin
                if (!bad && bytes < len_tbl[bi]) len_tbl[bi] = bytes;
                put(0, !bad, 0, 0);
            end
            cbpm_pkg::CMD_LINK: begin
                bad = bad || ob >= blk_count;
                if (!bad) begin
                    t = tail_of(bi, c);
                    end_tbl[t] = 0;
                    end_tbl[ob] = 1;
                    link_tbl[t] = ob;
                end
                put(0, !bad, 0, 0);
            end
            cbpm_pkg::CMD_PUSH: begin
                if (!bad) begin
                    if (is_nil(fifo_head) || is_nil(fifo_tail)) fifo_head = bi;
                    else link_tbl[fifo_tail] = bi;
                    fifo_tail = tail_of(bi, c);
                end
                put(0, !bad, 0, 0);
            end
            cbpm_pkg::CMD_POP: begin
                h = pop_chain();
                if (is_nil(h)) put(0, 0, 0, 0);
                else put(h, 1, 0, 0);
            end
            cbpm_pkg::CMD_WALK: begin
                if (bad) put(0, 0, 0, 0);
                else walk_emit(bi, cbpm_pkg::MAX_OUT);
            end
            default: begin
                if (is_nil(fifo_head)) begin
                    put(0, 0, 0, 0);
                end else begin
                    while (!is_nil(fifo_head) && burst.size() < cbpm_pkg::MAX_OUT) begin
                        h = pop_chain();
                        walk_emit(h, cbpm_pkg::MAX_OUT - burst.size());
                        free_chain(h);
                    end
                end
            end
        endcase
        blk0 = burst[0].blk;
        ok0 = burst[0].ok;
        foreach (burst[j]) begin
            burst[j].last = (j == burst.size() - 1);
            burst[j].free_cnt = free_cnt[cbpm_pkg::CNT_W-1:0];
            burst[j].low_water = low_water[cbpm_pkg::CNT_W-1:0];
            burst[j].fail_cnt = fail_cnt;
            expected_resps.push_back(burst[j]);
        end
    endfunction

    function void check(pool_resp_t act);
        pool_resp_t exp_r;
        resp_count++;
        if (expected_resps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response blk=%0d ok=%0d", act.blk, act.ok);
            return;
        end
        exp_r = expected_resps.pop_front();
        if (act !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on response %0d:", resp_count);
                $display("  exp blk=%0d ok=%0d used=%0d end=%0d last=%0d free=%0d low=%0d fail=%0d",
                         exp_r.blk, exp_r.ok, exp_r.used, exp_r.chain_end, exp_r.last,
                         exp_r.free_cnt, exp_r.low_water, exp_r.fail_cnt);
                $display("  act blk=%0d ok=%0d used=%0d end=%0d last=%0d free=%0d low=%0d fail=%0d",
                         act.blk, act.ok, act.used, act.chain_end, act.last,
                         act.free_cnt, act.low_water, act.fail_cnt);
            end
        end
    endfunction
endclass

module tb_chained_block_pool_manager;

    localparam int CYCLE_LIMIT = 5000000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [cbpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cbpm_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [cbpm_pkg::CMD_W-1:0]     s_command = '0;
    logic [cbpm_pkg::BLK_W-1:0]     s_block_index = '0;
    logic [cbpm_pkg::BLK_W-1:0]     s_other_block = '0;
    logic [cbpm_pkg::BYTES_W-1:0]   s_byte_count = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [cbpm_pkg::BLK_W-1:0]     m_out_block;
    logic                           m_ok;
    logic [cbpm_pkg::LEN_W-1:0]     m_used_bytes;
    logic                           m_chain_end;
    logic                           m_last;
    logic [cbpm_pkg::CNT_W-1:0]     m_free_blocks;
    logic [cbpm_pkg::CNT_W-1:0]     m_min_free_blocks;
    logic [cbpm_pkg::FAIL_W-1:0]    m_failed_allocs;

    pool_scoreboard sb = new();
    int unsigned    cycles = 0;
    bit             quiet = 0;     // no gaps on the request side while set
    int unsigned    live_heads[$]; // chains the bench believes it owns

    chained_block_pool_manager u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_block_index     (s_block_index),
        .s_other_block     (s_other_block),
        .s_byte_count      (s_byte_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_block       (m_out_block),
        .m_ok              (m_ok),
        .m_used_bytes      (m_used_bytes),
        .m_chain_end       (m_chain_end),
        .m_last            (m_last),
        .m_free_blocks     (m_free_blocks),
        .m_min_free_blocks (m_min_free_blocks),
        .m_failed_allocs   (m_failed_allocs)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[chained_block_pool_manager] ERROR");
            $finish;
        end
    end

    // response monitor: sampled values are the ones seen at the edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check({m_out_block, m_ok, m_used_bytes, m_chain_end, m_last,
                      m_free_blocks, m_min_free_blocks, m_failed_allocs});
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // response side backpressure, with stretches of none at all
    initial begin
        int unsigned n;
        forever begin
            if ($urandom_range(7) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    // one request; valid stays up across back-to-back requests
    task automatic send_req(input logic [cbpm_pkg::CMD_W-1:0] cmd, input int unsigned bi,
                            input int unsigned ob, input int unsigned bytes,
                            output int unsigned blk, output bit ok);
        int unsigned gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_block_index <= bi[cbpm_pkg::BLK_W-1:0];
        s_other_block <= ob[cbpm_pkg::BLK_W-1:0];
        s_byte_count  <= bytes[cbpm_pkg::BYTES_W-1:0];
        do @(posedge aclk); while (!s_ready);
        sb.note_request(cmd, bi[cbpm_pkg::BLK_W-1:0], ob[cbpm_pkg::BLK_W-1:0],
                        bytes[cbpm_pkg::BYTES_W-1:0], blk, ok);
    endtask

    // every response back, then let the sequencer settle
    task automatic wait_idle();
        if (s_valid) s_valid <= 1'b0;
        while (sb.expected_resps.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [cbpm_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[cbpm_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val[cbpm_pkg::CFG_W-1:0]);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_pool(input int unsigned bytes_val, input int unsigned count_val);
        wait_idle();
        write_reg(cbpm_pkg::REG_BLOCK_BYTES, bytes_val);
        write_reg(cbpm_pkg::REG_BLOCK_COUNT, count_val);
        live_heads.delete();
    endtask

    function automatic int unsigned take_live();
        int unsigned k, h;
        k = $urandom_range(live_heads.size() - 1);
        h = live_heads[k];
        live_heads.delete(k);
        return h;
    endfunction

    // Random traffic: mostly commands on chains the bench allocated, with
    // some fully random noise that may corrupt chains on purpose.
    task automatic run_random(input int unsigned n);
        int unsigned r, op, a, b, by, blk;
        bit ok;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) quiet = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            b = 0;
            by = 0;
            if (r < 15) begin
                op = $urandom_range(7);
                a = $urandom_range(63);
                b = $urandom_range(63);
                by = $urandom_range(524287);
            end else begin
                r = $urandom_range(99);
                if (r < 30)      op = cbpm_pkg::CMD_ALLOC;
                else if (r < 42) op = cbpm_pkg::CMD_FREE;
                else if (r < 52) op = cbpm_pkg::CMD_MARK;
                else if (r < 60) op = cbpm_pkg::CMD_LINK;
                else if (r < 72) op = cbpm_pkg::CMD_PUSH;
                else if (r < 80) op = cbpm_pkg::CMD_POP;
                else if (r < 92) op = cbpm_pkg::CMD_WALK;
                else             op = cbpm_pkg::CMD_DRAIN;
                if (live_heads.size() < ((op == cbpm_pkg::CMD_LINK) ? 2 : 1) &&
                    op != cbpm_pkg::CMD_POP && op != cbpm_pkg::CMD_DRAIN)
                    op = cbpm_pkg::CMD_ALLOC;
                a = 0;
                case (op)
                    cbpm_pkg::CMD_ALLOC: by = ($urandom_range(9) == 0) ?
                                    $urandom_range(262144) : $urandom_range(3 * sb.blk_bytes);
                    cbpm_pkg::CMD_FREE, cbpm_pkg::CMD_PUSH: a = take_live();
                    cbpm_pkg::CMD_MARK: begin
                        a = live_heads[$urandom_range(live_heads.size() - 1)];
                        by = $urandom_range(sb.blk_bytes);
                    end
                    cbpm_pkg::CMD_LINK: begin
                        a = live_heads[$urandom_range(live_heads.size() - 1)];
                        do b = take_live(); while (b == a && live_heads.size() > 0);
                        if (b == a) live_heads.push_back(a);
                    end
                    cbpm_pkg::CMD_WALK: a = live_heads[$urandom_range(live_heads.size() - 1)];
                    default: ;
                endcase
            end
            send_req(op[cbpm_pkg::CMD_W-1:0], a, b, by, blk, ok);
            if ((op == cbpm_pkg::CMD_ALLOC || op == cbpm_pkg::CMD_POP) && ok)
                live_heads.push_back(blk);
        end
    endtask

    initial begin
        int unsigned h1, h2, h3, blk;
        bit ok;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: the first request takes the whole pool so every block's
        // used mark and end mark have been written before any later read.
        send_req(cbpm_pkg::CMD_ALLOC, 0, 0, 4096, h1, ok);
        send_req(cbpm_pkg::CMD_WALK, h1, 0, 0, blk, ok);     // 64 responses
        send_req(cbpm_pkg::CMD_FREE, h1, 0, 0, blk, ok);
        send_req(cbpm_pkg::CMD_ALLOC, 0, 0, 0, h1, ok);      // zero bytes -> one block
        send_req(cbpm_pkg::CMD_ALLOC, 0, 0, 524287, blk, ok); // shortage, all ones
        send_req(cbpm_pkg::CMD_ALLOC, 0, 0, 262144, blk, ok);
        send_req(cbpm_pkg::CMD_ALLOC, 0, 0, 130, h2, ok);    // three blocks
        send_req(cbpm_pkg::CMD_MARK, h2, 0, 0, blk, ok);
        send_req(cbpm_pkg::CMD_MARK, h1, 0, 524287, blk, ok); // clamp keeps old mark
        send_req(cbpm_pkg::CMD_LINK, h1, 63, 0, blk, ok);    // other block at the top index
        send_req(cbpm_pkg::CMD_WALK, h1, 0, 0, blk, ok);
        send_req(cbpm_pkg::CMD_PUSH, h2, 0, 0, blk, ok);
        send_req(cbpm_pkg::CMD_ALLOC, 0, 0, 64, h3, ok);
        send_req(cbpm_pkg::CMD_PUSH, h3, 0, 0, blk, ok);
        send_req(cbpm_pkg::CMD_POP, 0, 0, 0, h2, ok);
        send_req(cbpm_pkg::CMD_WALK, h2, 0, 0, blk, ok);
        send_req(cbpm_pkg::CMD_PUSH, h2, 0, 0, blk, ok);
        send_req(cbpm_pkg::CMD_DRAIN, 0, 0, 0, blk, ok);     // two chains, then freed
        send_req(cbpm_pkg::CMD_POP, 0, 0, 0, blk, ok);       // empty FIFO
        send_req(cbpm_pkg::CMD_DRAIN, 0, 0, 0, blk, ok);     // empty FIFO
        send_req(cbpm_pkg::CMD_FREE, h1, 0, 0, blk, ok);

        // Single-block pool: second alloc fails, high indexes are bad.
        set_pool(4, 1);
        send_req(cbpm_pkg::CMD_ALLOC, 0, 0, 1, blk, ok);
        send_req(cbpm_pkg::CMD_ALLOC, 0, 0, 1, blk, ok);
        send_req(cbpm_pkg::CMD_FREE, 63, 0, 0, blk, ok);
        send_req(cbpm_pkg::CMD_MARK, 63, 0, 5, blk, ok);
        send_req(cbpm_pkg::CMD_LINK, 0, 63, 0, blk, ok);
        send_req(cbpm_pkg::CMD_PUSH, 40, 0, 0, blk, ok);
        send_req(cbpm_pkg::CMD_WALK, 5, 0, 0, blk, ok);
        run_random(25);

        set_pool(4096, 64);
        run_random(45);
        set_pool(0, 127);      // both saturate
        run_random(45);
        set_pool(8191, 0);
        run_random(20);
        set_pool($urandom_range(4, 200), $urandom_range(2, 64));
        run_random(45);
        set_pool(64, 64);
        run_random(45);

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("covered %0d requests and %0d responses over seven pool settings",
                 sb.req_count, sb.resp_count);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_resps.size() == 0) begin
            $display("[chained_block_pool_manager] OK");
        end else begin
            $display("[chained_block_pool_manager] ERROR");
        end
        $finish;
    end

endmodule

FILE: chained_block_pool_manager.f
+incdir+src
src/cbpm_pkg.sv
src/chained_block_pool_manager.sv
src/cbpm_checker.sv
bench/tb_chained_block_pool_manager.sv
